// ===== rtl/core/page_frame_allocator_refcount_macros.svh =====
// Assertion macros used by the page frame allocator top level.
`ifndef PAGE_FRAME_ALLOCATOR_REFCOUNT_MACROS_SVH
`define PAGE_FRAME_ALLOCATOR_REFCOUNT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFA_ASSERT_SAME(label, clk_s, rstn_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PFA_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/pfa_pkg.sv =====
// Package with widths, codes and types of the page frame allocator.
package pfa_pkg;

    // Default values of the top level parameters.
    localparam int DEF_FRAMES     = 65536;
    localparam int DEF_PAGE_SHIFT = 12;
    localparam int DEF_COUNT_BITS = 16;

    // Fixed payload widths of the channels and the configuration port.
    localparam int ACTION_W     = 3;
    localparam int ADDR_W       = 28;
    localparam int STATUS_W     = 3;
    localparam int REF_COUNT_W  = 16;
    localparam int FREE_PAGES_W = 17;
    localparam int CFG_DATA_W   = 17;
    localparam int CFG_INDEX_W  = 1;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes and reset values.
    localparam logic [CFG_INDEX_W-1:0] REG_LOW_FRAME = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TOP_FRAME = 1'd1;
    localparam logic [CFG_DATA_W-1:0]  LOW_FRAME_RESET = 17'd0;
    localparam logic [CFG_DATA_W-1:0]  TOP_FRAME_RESET = 17'd65536;

    // Request action codes.
    localparam logic [ACTION_W-1:0] ACT_FREE  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_ALLOC = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_INC   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_DEC   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ  = 3'd4;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_BAD_ADDR   = 3'd1,
        ST_NO_FREE    = 3'd2,
        ST_STACK_FULL = 3'd3,
        ST_SATURATED  = 3'd4
    } status_t;

    // Classified command handed from the front to the back.
    typedef enum logic [2:0] {
        OP_FREE,
        OP_ALLOC,
        OP_INC,
        OP_DEC,
        OP_READ,
        OP_BAD,
        OP_NOP
    } pfa_op_t;

endpackage

// ===== rtl/core/pfa_req_if.sv =====
// Request channel interface: action and physical address.
interface pfa_req_if
    import pfa_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [ADDR_W-1:0]   phys_addr;

    modport source (output valid, output action, output phys_addr, input ready);
    modport sink   (input valid, input action, input phys_addr, output ready);
endinterface

// ===== rtl/core/pfa_rsp_if.sv =====
// Result channel interface: status, page address, count and free page total.
interface pfa_rsp_if
    import pfa_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic [ADDR_W-1:0]       page_addr;
    logic [REF_COUNT_W-1:0]  ref_count;
    logic [FREE_PAGES_W-1:0] free_pages;

    modport source (output valid, output status, output page_addr, output ref_count,
                    output free_pages, input ready);
    modport sink   (input valid, input status, input page_addr, input ref_count,
                    input free_pages, output ready);
endinterface

// ===== rtl/core/pfa_front.sv =====
// Front part: configuration registers, request accept and address classification.
module pfa_front
    import pfa_pkg::*;
#(
    parameter int FRAMES     = DEF_FRAMES,
    parameter int PAGE_SHIFT = DEF_PAGE_SHIFT,
    localparam int FRAME_W   = $clog2(FRAMES)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    pfa_req_if.sink                req,
    input  logic                   clearing,
    output logic                   push_valid,
    input  logic                   push_ready,
    output pfa_op_t                push_op,
    output logic [FRAME_W-1:0]     push_frame
);

    logic [CFG_DATA_W-1:0] low_frame_reg;
    logic [CFG_DATA_W-1:0] top_frame_reg;
    logic [31:0]           frame_num;
    logic                  addr_ok;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_frame_reg <= LOW_FRAME_RESET;
            top_frame_reg <= TOP_FRAME_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LOW_FRAME: low_frame_reg <= cfg_data;
                REG_TOP_FRAME: top_frame_reg <= cfg_data;
            endcase
        end
    end

    // Address check: page aligned and inside the allowed frame window.
    always_comb
    begin
        frame_num = 32'(req.phys_addr >> PAGE_SHIFT);
        addr_ok   = (req.phys_addr[PAGE_SHIFT-1:0] == '0)
                 && (frame_num >= 32'(low_frame_reg))
                 && (frame_num <  32'(top_frame_reg))
                 && (frame_num <  32'(FRAMES));
    end

    // Classify the request into a command for the back part.
    always_comb
    begin
        unique case (req.action)
            ACT_FREE:  push_op = addr_ok ? OP_FREE : OP_BAD;
            ACT_ALLOC: push_op = OP_ALLOC;
            ACT_INC:   push_op = addr_ok ? OP_INC : OP_BAD;
            ACT_DEC:   push_op = addr_ok ? OP_DEC : OP_BAD;
            ACT_READ:  push_op = addr_ok ? OP_READ : OP_BAD;
            default:   push_op = OP_NOP;
        endcase
    end

    // No item enters while the count table is being cleared.
    assign push_frame = frame_num[FRAME_W-1:0];
    assign push_valid = req.valid && !clearing;
    assign req.ready  = push_ready && !clearing;

endmodule

// ===== rtl/core/pfa_queue.sv =====
// Short command queue that decouples the front part from the back part.
module pfa_queue
    import pfa_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (cnt_reg != CNT_W'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/pfa_back.sv =====
// Back part: free stack and count table memories, command execution and result register.
module pfa_back
    import pfa_pkg::*;
#(
    parameter int FRAMES     = DEF_FRAMES,
    parameter int PAGE_SHIFT = DEF_PAGE_SHIFT,
    parameter int COUNT_BITS = DEF_COUNT_BITS,
    localparam int FRAME_W   = $clog2(FRAMES)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  pfa_op_t            pop_op,
    input  logic [FRAME_W-1:0] pop_frame,
    output logic               clearing,
    pfa_rsp_if.source          rsp
);

    localparam int DEPTH_W = $clog2(FRAMES + 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                  state_reg, state_next;
    logic [FRAME_W-1:0]      clr_idx_reg, clr_idx_next;
    logic [DEPTH_W-1:0]      depth_reg, depth_next;
    pfa_op_t                 op_reg, op_next;
    logic [FRAME_W-1:0]      frame_reg, frame_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    status_t                 status_reg, status_next;
    logic [ADDR_W-1:0]       page_addr_reg, page_addr_next;
    logic [REF_COUNT_W-1:0]  ref_count_reg, ref_count_next;
    logic [FREE_PAGES_W-1:0] free_pages_reg, free_pages_next;

    // Memories and their registered read data.
    logic [COUNT_BITS-1:0] count_mem [FRAMES];
    logic [FRAME_W-1:0]    stack_mem [FRAMES];
    logic [COUNT_BITS-1:0] cnt_rd_reg;
    logic [FRAME_W-1:0]    stk_rd_reg;

    logic                  mem_rd;
    logic                  out_free;
    logic                  do_exec;
    logic [FRAME_W-1:0]    stk_raddr;
    logic                  stack_empty;
    logic                  stack_full;

    // Results of the command in execution.
    logic                  ex_cnt_we;
    logic [FRAME_W-1:0]    ex_cnt_waddr;
    logic [COUNT_BITS-1:0] ex_cnt_wdata;
    logic                  ex_stk_we;
    logic [DEPTH_W-1:0]    ex_depth;
    status_t               ex_status;
    logic [ADDR_W-1:0]     ex_page;
    logic [COUNT_BITS-1:0] ex_count;

    assign clearing    = (state_reg == S_CLEAR);
    assign pop_ready   = (state_reg == S_IDLE);
    assign mem_rd      = pop_ready && pop_valid;
    assign out_free    = !rsp_valid_reg || rsp.ready;
    assign do_exec     = (state_reg == S_EXEC) && out_free;
    assign stk_raddr   = FRAME_W'(depth_reg - DEPTH_W'(1));
    assign stack_empty = (depth_reg == '0);
    assign stack_full  = (depth_reg == DEPTH_W'(FRAMES));

    // Execute the held command on the read data registered when it was accepted.
    always_comb
    begin
        ex_cnt_we    = 1'b0;
        ex_cnt_waddr = frame_reg;
        ex_cnt_wdata = '0;
        ex_stk_we    = 1'b0;
        ex_depth     = depth_reg;
        ex_status    = ST_OK;
        ex_page      = '0;
        ex_count     = '0;
        unique case (op_reg)
            OP_ALLOC:
            begin
                if (stack_empty)
                begin
                    ex_status = ST_NO_FREE;
                end
                else
                begin
                    ex_cnt_we    = 1'b1;
                    ex_cnt_waddr = stk_rd_reg;
                    ex_cnt_wdata = COUNT_BITS'(1);
                    ex_depth     = depth_reg - DEPTH_W'(1);
                    ex_count     = COUNT_BITS'(1);
                    ex_page      = ADDR_W'(ADDR_W'(stk_rd_reg) << PAGE_SHIFT);
                end
            end
            OP_FREE:
            begin
                if (stack_full)
                begin
                    ex_status = ST_STACK_FULL;
                    ex_count  = cnt_rd_reg;
                end
                else
                begin
                    ex_stk_we = 1'b1;
                    ex_cnt_we = 1'b1;
                    ex_depth  = depth_reg + DEPTH_W'(1);
                end
            end
            OP_INC:
            begin
                if (cnt_rd_reg == COUNT_MAX)
                begin
                    ex_status = ST_SATURATED;
                    ex_count  = cnt_rd_reg;
                end
                else
                begin
                    ex_cnt_we    = 1'b1;
                    ex_cnt_wdata = cnt_rd_reg + COUNT_BITS'(1);
                    ex_count     = ex_cnt_wdata;
                end
            end
            OP_DEC:
            begin
                if (cnt_rd_reg == '0)
                begin
                    ex_status = ST_SATURATED;
                end
                else
                begin
                    ex_cnt_we    = 1'b1;
                    ex_cnt_wdata = cnt_rd_reg - COUNT_BITS'(1);
                    ex_count     = ex_cnt_wdata;
                end
            end
            OP_READ:
            begin
                ex_count = cnt_rd_reg;
            end
            OP_BAD:
            begin
                ex_status = ST_BAD_ADDR;
            end
            OP_NOP:
            begin
                ex_status = ST_OK;
            end
            default:
            begin
                ex_status = ST_OK;
            end
        endcase
    end

    // Count table: one write port shared by the clearing pass and execution.
    always_ff @(posedge clk)
    begin
        if (clearing)
        begin
            count_mem[clr_idx_reg] <= '0;
        end
        else if (do_exec && ex_cnt_we)
        begin
            count_mem[ex_cnt_waddr] <= ex_cnt_wdata;
        end
        if (mem_rd)
        begin
            cnt_rd_reg <= count_mem[pop_frame];
        end
    end

    // Free stack: push at the depth, pop reads the entry below it.
    always_ff @(posedge clk)
    begin
        if (do_exec && ex_stk_we)
        begin
            stack_mem[depth_reg[FRAME_W-1:0]] <= frame_reg;
        end
        if (mem_rd)
        begin
            stk_rd_reg <= stack_mem[stk_raddr];
        end
    end

    // Sequencer next state and result register loading.
    always_comb
    begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        depth_next      = depth_reg;
        op_next         = op_reg;
        frame_next      = frame_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        status_next     = status_reg;
        page_addr_next  = page_addr_reg;
        ref_count_next  = ref_count_reg;
        free_pages_next = free_pages_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + FRAME_W'(1);
                if (clr_idx_reg == FRAME_W'(FRAMES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (pop_valid)
                begin
                    op_next    = pop_op;
                    frame_next = pop_frame;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    depth_next      = ex_depth;
                    rsp_valid_next  = 1'b1;
                    status_next     = ex_status;
                    page_addr_next  = ex_page;
                    ref_count_next  = REF_COUNT_W'(ex_count);
                    free_pages_next = FREE_PAGES_W'(ex_depth);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_idx_reg    <= '0;
            depth_reg      <= '0;
            op_reg         <= OP_NOP;
            frame_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
            status_reg     <= ST_OK;
            page_addr_reg  <= '0;
            ref_count_reg  <= '0;
            free_pages_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            depth_reg      <= depth_next;
            op_reg         <= op_next;
            frame_reg      <= frame_next;
            rsp_valid_reg  <= rsp_valid_next;
            status_reg     <= status_next;
            page_addr_reg  <= page_addr_next;
            ref_count_reg  <= ref_count_next;
            free_pages_reg <= free_pages_next;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = status_reg;
    assign rsp.page_addr  = page_addr_reg;
    assign rsp.ref_count  = ref_count_reg;
    assign rsp.free_pages = free_pages_reg;

endmodule

// ===== rtl/core/page_frame_allocator_refcount.sv =====
// Top level of the page frame allocator with per-frame reference counts.
//
//   Channel  Direction  Handshake          Payload
//   req      in         req.valid/ready    action, phys_addr
//   rsp      out        rsp.valid/ready    status, page_addr, ref_count, free_pages
//   cfg      in         cfg_we             cfg_index, cfg_data
//
// In the back part an item's count table and free stack entries are read when it is
// accepted in the idle state; the execute state then writes them and loads the result
// register. The back part takes no new item until that item has left the execute state.
// After reset the count table is cleared one entry a cycle, all FRAMES entries
// (65536 by default); req.ready stays low during that pass.
// A stalled result holds the back part; the two-entry queue keeps the front accepting
// until it holds two items.
`include "page_frame_allocator_refcount_macros.svh"

module page_frame_allocator_refcount
    import pfa_pkg::*;
#(
    parameter int FRAMES     = DEF_FRAMES,
    parameter int PAGE_SHIFT = DEF_PAGE_SHIFT,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    pfa_req_if.sink                req,
    pfa_rsp_if.source              rsp,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int FRAME_W = $clog2(FRAMES);
    localparam int OP_W    = $bits(pfa_op_t);
    localparam int ENTRY_W = OP_W + FRAME_W;

    logic               clearing;
    logic               push_valid;
    logic               push_ready;
    pfa_op_t            push_op;
    logic [FRAME_W-1:0] push_frame;
    logic               pop_valid;
    logic               pop_ready;
    logic [ENTRY_W-1:0] pop_data;
    pfa_op_t            pop_op;
    logic [FRAME_W-1:0] pop_frame;

    // Accept and classify requests.
    pfa_front #(
        .FRAMES     (FRAMES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req        (req),
        .clearing   (clearing),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op),
        .push_frame (push_frame)
    );

    // Command queue between the two parts.
    pfa_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_op, push_frame}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    assign pop_op    = pfa_op_t'(pop_data[ENTRY_W-1:FRAME_W]);
    assign pop_frame = pop_data[FRAME_W-1:0];

    // Execute commands against the stack and the count table.
    pfa_back #(
        .FRAMES     (FRAMES),
        .PAGE_SHIFT (PAGE_SHIFT),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_op    (pop_op),
        .pop_frame (pop_frame),
        .clearing  (clearing),
        .rsp       (rsp)
    );

    // Checks on the block's own behavior.
    `PFA_ASSERT_SAME(a_no_accept_in_clear, clk, rst_n, req.valid && req.ready, !clearing, "item accepted during the clearing pass")
    `PFA_ASSERT_NEXT(a_clear_once, clk, rst_n, !clearing, !clearing, "clearing pass restarted")
    `PFA_ASSERT_SAME(a_alloc_count_one, clk, rst_n, rsp.valid && rsp.page_addr != '0, rsp.status == ST_OK && rsp.ref_count == REF_COUNT_W'(1), "allocated page without count one")
    `PFA_ASSERT_SAME(a_bad_addr_clean, clk, rst_n, rsp.valid && rsp.status == ST_BAD_ADDR, rsp.ref_count == '0 && rsp.page_addr == '0, "bad address result carries data")

endmodule
